/* hw/rtl/disk_elastic_collision_response_assert.svh */
// Assertion macros used by the collision response checker.
`ifndef DISK_ELASTIC_COLLISION_RESPONSE_ASSERT_SVH
`define DISK_ELASTIC_COLLISION_RESPONSE_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define DCR_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("collision response assertion failed");

// Clocked assertion that also holds across reset.
`define DCR_ASSERT(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("collision response assertion failed");

`endif

/* hw/rtl/dcr_pkg.sv */
// Shared types and constants of the disk collision response block.
package dcr_pkg;

   localparam int DCR_QUEUE_DEPTH = 4;
   // quotient bits of the center-of-mass and the reflection dividers
   localparam int DCR_COM_QW      = 21;
   localparam int DCR_COR_QW      = 24;

   typedef struct packed {
      logic               hit;
      logic signed [18:0] dx;
      logic signed [18:0] dy;
      logic        [37:0] d2;
      logic signed [19:0] vxa;
      logic signed [19:0] vya;
      logic signed [19:0] vxb;
      logic signed [19:0] vyb;
      logic        [7:0]  ma;
      logic        [7:0]  mb;
   } dcr_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dcr_qstat_type;

endpackage

/* hw/rtl/dcr_if.sv */
// Request and response channel interfaces.
interface dcr_req_if;
   logic               valid;
   logic               ready;
   logic signed [17:0] pos_x_a;
   logic signed [17:0] pos_y_a;
   logic signed [17:0] pos_x_b;
   logic signed [17:0] pos_y_b;
   logic signed [19:0] vel_x_a;
   logic signed [19:0] vel_y_a;
   logic signed [19:0] vel_x_b;
   logic signed [19:0] vel_y_b;
   logic        [7:0]  mass_a;
   logic        [7:0]  mass_b;
   logic        [15:0] radius_a;
   logic        [15:0] radius_b;

   modport source (output valid, pos_x_a, pos_y_a, pos_x_b, pos_y_b, vel_x_a, vel_y_a,
                   vel_x_b, vel_y_b, mass_a, mass_b, radius_a, radius_b, input ready);
   modport sink   (input valid, pos_x_a, pos_y_a, pos_x_b, pos_y_b, vel_x_a, vel_y_a,
                   vel_x_b, vel_y_b, mass_a, mass_b, radius_a, radius_b, output ready);
endinterface

interface dcr_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [19:0] new_vel_x_a;
   logic signed [19:0] new_vel_y_a;
   logic signed [19:0] new_vel_x_b;
   logic signed [19:0] new_vel_y_b;

   modport source (output valid, hit, new_vel_x_a, new_vel_y_a, new_vel_x_b, new_vel_y_b,
                   input ready);
   modport sink   (input valid, hit, new_vel_x_a, new_vel_y_a, new_vel_x_b, new_vel_y_b,
                   output ready);
endinterface

/* hw/rtl/dcr_queue.sv */
// Small FIFO between the classify front and the response back end.
module dcr_queue #(
   parameter int DEPTH = dcr_pkg::DCR_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  dcr_pkg::dcr_item_type  push_item,
   input  logic                   pop,
   output dcr_pkg::dcr_item_type  head_item,
   output dcr_pkg::dcr_qstat_type stat
);
   import dcr_pkg::*;

   localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   dcr_item_type   mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

/* hw/rtl/dcr_div.sv */
// Pipelined restoring divider, floor quotient of a signed numerator, one bit per stage.
module dcr_div #(
   parameter int NW = 32,
   parameter int DW = 10,
   parameter int QW = 21
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [NW-1:0] num,
   input  logic        [DW-1:0] den,
   output logic signed [QW:0]   quo
);
   localparam int MW = NW - 1;
   localparam int SW = DW + QW;
   localparam int CW = (MW > SW) ? MW : SW;

   logic [MW-1:0] rem_ff [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic [DW-1:0] den_ff [QW+1];
   logic          neg_ff [QW+1];

   // negative numerators go through as ~num, the quotient is inverted at the end
   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= num[NW-1];
         rem_ff[0] <= num[NW-1] ? ~num[MW-1:0] : num[MW-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_stage
      logic [CW-1:0] rem_ext;
      logic [CW-1:0] dsh;
      logic          take;

      assign rem_ext = CW'(rem_ff[k-1]);
      assign dsh     = CW'(den_ff[k-1]) << (QW - k);
      assign take    = (rem_ext >= dsh);

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[k] <= neg_ff[k-1];
            den_ff[k] <= den_ff[k-1];
            rem_ff[k] <= take ? MW'(rem_ext - dsh) : rem_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (QW'(take) << (QW - k));
         end
      end
   end

   assign quo = neg_ff[QW] ? ~$signed({1'b0, q_ff[QW]}) : $signed({1'b0, q_ff[QW]});

endmodule

/* hw/rtl/dcr_front.sv */
// Front end: takes requests, forms the center offset and decides contact.
module dcr_front (
   input  logic                   clock,
   input  logic                   reset,
   dcr_req_if.sink                req_chan,
   input  dcr_pkg::dcr_qstat_type qstat,
   output logic                   push,
   output dcr_pkg::dcr_item_type  push_item
);
   import dcr_pkg::*;

   logic adv;

   // stage 1: registered request
   logic               v1_ff;
   logic signed [17:0] xa1_ff, ya1_ff, xb1_ff, yb1_ff;
   logic signed [19:0] vxa1_ff, vya1_ff, vxb1_ff, vyb1_ff;
   logic        [7:0]  ma1_ff, mb1_ff;
   logic        [15:0] ra1_ff, rb1_ff;

   // stage 2: differences
   logic               v2_ff;
   logic signed [18:0] dx2_ff, dy2_ff;
   logic signed [20:0] dvx2_ff, dvy2_ff;
   logic        [16:0] rs2_ff;
   logic signed [19:0] vxa2_ff, vya2_ff, vxb2_ff, vyb2_ff;
   logic        [7:0]  ma2_ff, mb2_ff;

   // stage 3: products
   logic               v3_ff;
   logic signed [37:0] sqx3_ff, sqy3_ff;
   logic        [33:0] rsq3_ff;
   logic signed [39:0] apx3_ff, apy3_ff;
   logic signed [18:0] dx3_ff, dy3_ff;
   logic signed [19:0] vxa3_ff, vya3_ff, vxb3_ff, vyb3_ff;
   logic        [7:0]  ma3_ff, mb3_ff;

   // stage 4: sums
   logic               v4_ff;
   logic        [37:0] d2_4_ff;
   logic        [33:0] rsq4_ff;
   logic signed [40:0] appr4_ff;
   logic signed [18:0] dx4_ff, dy4_ff;
   logic signed [19:0] vxa4_ff, vya4_ff, vxb4_ff, vyb4_ff;
   logic        [7:0]  ma4_ff, mb4_ff;

   assign adv            = !v4_ff || !qstat.full;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xa1_ff  <= req_chan.pos_x_a;
         ya1_ff  <= req_chan.pos_y_a;
         xb1_ff  <= req_chan.pos_x_b;
         yb1_ff  <= req_chan.pos_y_b;
         vxa1_ff <= req_chan.vel_x_a;
         vya1_ff <= req_chan.vel_y_a;
         vxb1_ff <= req_chan.vel_x_b;
         vyb1_ff <= req_chan.vel_y_b;
         ma1_ff  <= req_chan.mass_a;
         mb1_ff  <= req_chan.mass_b;
         ra1_ff  <= req_chan.radius_a;
         rb1_ff  <= req_chan.radius_b;

         dx2_ff  <= 19'(xa1_ff) - 19'(xb1_ff);
         dy2_ff  <= 19'(ya1_ff) - 19'(yb1_ff);
         dvx2_ff <= 21'(vxa1_ff) - 21'(vxb1_ff);
         dvy2_ff <= 21'(vya1_ff) - 21'(vyb1_ff);
         rs2_ff  <= 17'(ra1_ff) + 17'(rb1_ff);
         vxa2_ff <= vxa1_ff;
         vya2_ff <= vya1_ff;
         vxb2_ff <= vxb1_ff;
         vyb2_ff <= vyb1_ff;
         ma2_ff  <= ma1_ff;
         mb2_ff  <= mb1_ff;

         sqx3_ff <= dx2_ff * dx2_ff;
         sqy3_ff <= dy2_ff * dy2_ff;
         rsq3_ff <= rs2_ff * rs2_ff;
         apx3_ff <= dvx2_ff * dx2_ff;
         apy3_ff <= dvy2_ff * dy2_ff;
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         vxa3_ff <= vxa2_ff;
         vya3_ff <= vya2_ff;
         vxb3_ff <= vxb2_ff;
         vyb3_ff <= vyb2_ff;
         ma3_ff  <= ma2_ff;
         mb3_ff  <= mb2_ff;

         d2_4_ff  <= 38'(sqx3_ff) + 38'(sqy3_ff);
         rsq4_ff  <= rsq3_ff;
         appr4_ff <= 41'(apx3_ff) + 41'(apy3_ff);
         dx4_ff   <= dx3_ff;
         dy4_ff   <= dy3_ff;
         vxa4_ff  <= vxa3_ff;
         vya4_ff  <= vya3_ff;
         vxb4_ff  <= vxb3_ff;
         vyb4_ff  <= vyb3_ff;
         ma4_ff   <= ma3_ff;
         mb4_ff   <= mb3_ff;
      end
   end

   assign push          = v4_ff && adv;
   assign push_item.hit = (d2_4_ff < 38'(rsq4_ff)) && appr4_ff[40];
   assign push_item.dx  = dx4_ff;
   assign push_item.dy  = dy4_ff;
   assign push_item.d2  = d2_4_ff;
   assign push_item.vxa = vxa4_ff;
   assign push_item.vya = vya4_ff;
   assign push_item.vxb = vxb4_ff;
   assign push_item.vyb = vyb4_ff;
   assign push_item.ma  = ma4_ff;
   assign push_item.mb  = mb4_ff;

endmodule

/* hw/rtl/dcr_back.sv */
// Back end: center-of-mass velocity, reflection about the center line, saturation.
module dcr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dcr_pkg::dcr_item_type  head_item,
   input  dcr_pkg::dcr_qstat_type qstat,
   output logic                   pop,
   dcr_rsp_if.source              rsp_chan
);
   import dcr_pkg::*;

   localparam int LC = DCR_COM_QW + 1;
   localparam int LR = DCR_COR_QW + 1;

   function automatic logic signed [19:0] sat_vel(input logic signed [25:0] v);
      logic signed [19:0] r;
      if (v > 26'sd524287) begin
         r = 20'sd524287;
      end else if (v < -26'sd524288) begin
         r = -20'sd524288;
      end else begin
         r = v[19:0];
      end
      return r;
   endfunction

   logic adv;
   logic o_vld_ff;

   assign adv = !o_vld_ff || rsp_chan.ready;
   assign pop = adv && !qstat.empty;

   // stage A: mass products
   logic               a_vld_ff;
   dcr_item_type       a_it_ff;
   logic signed [28:0] a_pxa_ff, a_pya_ff, a_pxb_ff, a_pyb_ff;
   logic        [8:0]  a_msum_ff;
   logic        [7:0]  ma_e, mb_e;

   always_comb begin
      ma_e = head_item.ma;
      mb_e = head_item.mb;
      if (head_item.ma == '0 && head_item.mb == '0) begin
         ma_e = 8'd1;
         mb_e = 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_it_ff   <= head_item;
         a_pxa_ff  <= head_item.vxa * $signed({1'b0, ma_e});
         a_pya_ff  <= head_item.vya * $signed({1'b0, ma_e});
         a_pxb_ff  <= head_item.vxb * $signed({1'b0, mb_e});
         a_pyb_ff  <= head_item.vyb * $signed({1'b0, mb_e});
         a_msum_ff <= 9'(ma_e) + 9'(mb_e);
      end
   end

   // center-of-mass velocity: round((va*ma + vb*mb) / msum)
   logic signed [31:0]         num_cx, num_cy;
   logic        [9:0]          den_c;
   logic signed [DCR_COM_QW:0] cx, cy;

   assign num_cx = 32'((32'(a_pxa_ff) + 32'(a_pxb_ff)) << 1) + 32'(a_msum_ff);
   assign num_cy = 32'((32'(a_pya_ff) + 32'(a_pyb_ff)) << 1) + 32'(a_msum_ff);
   assign den_c  = {a_msum_ff, 1'b0};

   dcr_div #(.NW(32), .DW(10), .QW(DCR_COM_QW)) u_div_cx (
      .clock(clock), .en(adv), .num(num_cx), .den(den_c), .quo(cx)
   );
   dcr_div #(.NW(32), .DW(10), .QW(DCR_COM_QW)) u_div_cy (
      .clock(clock), .en(adv), .num(num_cy), .den(den_c), .quo(cy)
   );

   logic         c_vld_ff [LC];
   dcr_item_type c_it_ff  [LC];

   always_ff @(posedge clock) begin
      if (adv) begin
         c_it_ff[0] <= a_it_ff;
         for (int k = 1; k < LC; k++) begin
            c_it_ff[k] <= c_it_ff[k-1];
         end
      end
   end

   // stage U: velocities relative to the center of mass
   logic               u_vld_ff;
   dcr_item_type       u_it_ff;
   logic signed [22:0] u_xa_ff, u_ya_ff, u_xb_ff, u_yb_ff;

   // stage P: projections on the center line
   logic               p_vld_ff;
   dcr_item_type       p_it_ff;
   logic signed [41:0] p_m1_ff, p_m2_ff, p_m3_ff, p_m4_ff;

   // stage S: dot products
   logic               s_vld_ff;
   dcr_item_type       s_it_ff;
   logic signed [42:0] s_pa_ff, s_pb_ff;

   // stage H: split partial products of (u.d)d
   logic               h_vld_ff;
   dcr_item_type       h_it_ff;
   logic signed [41:0] h_ahx_ff, h_ahy_ff, h_bhx_ff, h_bhy_ff;
   logic signed [39:0] h_alx_ff, h_aly_ff, h_blx_ff, h_bly_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         u_it_ff  <= c_it_ff[LC-1];
         u_xa_ff  <= 23'(c_it_ff[LC-1].vxa) - 23'(cx);
         u_ya_ff  <= 23'(c_it_ff[LC-1].vya) - 23'(cy);
         u_xb_ff  <= 23'(c_it_ff[LC-1].vxb) - 23'(cx);
         u_yb_ff  <= 23'(c_it_ff[LC-1].vyb) - 23'(cy);

         p_it_ff  <= u_it_ff;
         p_m1_ff  <= u_xa_ff * u_it_ff.dx;
         p_m2_ff  <= u_ya_ff * u_it_ff.dy;
         p_m3_ff  <= u_xb_ff * u_it_ff.dx;
         p_m4_ff  <= u_yb_ff * u_it_ff.dy;

         s_it_ff  <= p_it_ff;
         s_pa_ff  <= 43'(p_m1_ff) + 43'(p_m2_ff);
         s_pb_ff  <= 43'(p_m3_ff) + 43'(p_m4_ff);

         h_it_ff  <= s_it_ff;
         h_ahx_ff <= $signed(s_pa_ff[42:20]) * s_it_ff.dx;
         h_ahy_ff <= $signed(s_pa_ff[42:20]) * s_it_ff.dy;
         h_bhx_ff <= $signed(s_pb_ff[42:20]) * s_it_ff.dx;
         h_bhy_ff <= $signed(s_pb_ff[42:20]) * s_it_ff.dy;
         h_alx_ff <= $signed({1'b0, s_pa_ff[19:0]}) * s_it_ff.dx;
         h_aly_ff <= $signed({1'b0, s_pa_ff[19:0]}) * s_it_ff.dy;
         h_blx_ff <= $signed({1'b0, s_pb_ff[19:0]}) * s_it_ff.dx;
         h_bly_ff <= $signed({1'b0, s_pb_ff[19:0]}) * s_it_ff.dy;
      end
   end

   // correction: round(2 p d_k / |d|^2), numerator 4 p d_k + |d|^2 over 2 |d|^2
   logic signed [65:0]         n_xa, n_ya, n_xb, n_yb;
   logic        [38:0]         den_r;
   logic signed [DCR_COR_QW:0] q_xa, q_ya, q_xb, q_yb;

   assign n_xa  = (((66'(h_ahx_ff) <<< 20) + 66'(h_alx_ff)) <<< 2) + 66'(h_it_ff.d2);
   assign n_ya  = (((66'(h_ahy_ff) <<< 20) + 66'(h_aly_ff)) <<< 2) + 66'(h_it_ff.d2);
   assign n_xb  = (((66'(h_bhx_ff) <<< 20) + 66'(h_blx_ff)) <<< 2) + 66'(h_it_ff.d2);
   assign n_yb  = (((66'(h_bhy_ff) <<< 20) + 66'(h_bly_ff)) <<< 2) + 66'(h_it_ff.d2);
   assign den_r = {h_it_ff.d2, 1'b0};

   dcr_div #(.NW(66), .DW(39), .QW(DCR_COR_QW)) u_div_xa (
      .clock(clock), .en(adv), .num(n_xa), .den(den_r), .quo(q_xa)
   );
   dcr_div #(.NW(66), .DW(39), .QW(DCR_COR_QW)) u_div_ya (
      .clock(clock), .en(adv), .num(n_ya), .den(den_r), .quo(q_ya)
   );
   dcr_div #(.NW(66), .DW(39), .QW(DCR_COR_QW)) u_div_xb (
      .clock(clock), .en(adv), .num(n_xb), .den(den_r), .quo(q_xb)
   );
   dcr_div #(.NW(66), .DW(39), .QW(DCR_COR_QW)) u_div_yb (
      .clock(clock), .en(adv), .num(n_yb), .den(den_r), .quo(q_yb)
   );

   logic         r_vld_ff [LR];
   dcr_item_type r_it_ff  [LR];

   always_ff @(posedge clock) begin
      if (adv) begin
         r_it_ff[0] <= h_it_ff;
         for (int k = 1; k < LR; k++) begin
            r_it_ff[k] <= r_it_ff[k-1];
         end
      end
   end

   // valid bits of all back stages
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         u_vld_ff <= 1'b0;
         p_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
         for (int k = 0; k < LC; k++) begin
            c_vld_ff[k] <= 1'b0;
         end
         for (int k = 0; k < LR; k++) begin
            r_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         a_vld_ff    <= pop;
         c_vld_ff[0] <= a_vld_ff;
         for (int k = 1; k < LC; k++) begin
            c_vld_ff[k] <= c_vld_ff[k-1];
         end
         u_vld_ff    <= c_vld_ff[LC-1];
         p_vld_ff    <= u_vld_ff;
         s_vld_ff    <= p_vld_ff;
         h_vld_ff    <= s_vld_ff;
         r_vld_ff[0] <= h_vld_ff;
         for (int k = 1; k < LR; k++) begin
            r_vld_ff[k] <= r_vld_ff[k-1];
         end
         o_vld_ff    <= r_vld_ff[LR-1];
      end
   end

   // output register
   dcr_item_type       fin;
   logic               o_hit_ff;
   logic signed [19:0] o_xa_ff, o_ya_ff, o_xb_ff, o_yb_ff;

   assign fin = r_it_ff[LR-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         o_hit_ff <= fin.hit;
         if (fin.hit) begin
            o_xa_ff <= sat_vel(26'(fin.vxa) - 26'(q_xa));
            o_ya_ff <= sat_vel(26'(fin.vya) - 26'(q_ya));
            o_xb_ff <= sat_vel(26'(fin.vxb) - 26'(q_xb));
            o_yb_ff <= sat_vel(26'(fin.vyb) - 26'(q_yb));
         end else begin
            o_xa_ff <= fin.vxa;
            o_ya_ff <= fin.vya;
            o_xb_ff <= fin.vxb;
            o_yb_ff <= fin.vyb;
         end
      end
   end

   assign rsp_chan.valid       = o_vld_ff;
   assign rsp_chan.hit         = o_hit_ff;
   assign rsp_chan.new_vel_x_a = o_xa_ff;
   assign rsp_chan.new_vel_y_a = o_ya_ff;
   assign rsp_chan.new_vel_x_b = o_xb_ff;
   assign rsp_chan.new_vel_y_b = o_yb_ff;

endmodule

/* hw/rtl/disk_elastic_collision_response.sv */
// A request passes the front stages and the queue, then the back stages with their dividers;
// the one-bit-per-stage dividers set the latency.
// Throughput: one request per cycle while the queue is not full.
// The back end stalls as a whole when the response is not taken; the queue absorbs
// the front end's requests meanwhile.
// Reset: synchronous, clears all valid bits and the queue; no clearing pass.
module disk_elastic_collision_response #(
   parameter int QUEUE_DEPTH = dcr_pkg::DCR_QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   dcr_req_if.sink   req_chan,
   dcr_rsp_if.source rsp_chan
);
   import dcr_pkg::*;

   logic          push;
   logic          pop;
   dcr_item_type  push_item;
   dcr_item_type  head_item;
   dcr_qstat_type qstat;

   dcr_front u_front (
      .clock(clock), .reset(reset), .req_chan(req_chan), .qstat(qstat),
      .push(push), .push_item(push_item)
   );

   dcr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_item(push_item),
      .pop(pop), .head_item(head_item), .stat(qstat)
   );

   dcr_back u_back (
      .clock(clock), .reset(reset), .head_item(head_item), .qstat(qstat),
      .pop(pop), .rsp_chan(rsp_chan)
   );

endmodule

/* hw/rtl/dcr_checker.sv */
// Port-level checker of the collision response block and its bind.
`include "disk_elastic_collision_response_assert.svh"

module dcr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_hit,
   input logic signed [19:0] rsp_vxa,
   input logic signed [19:0] rsp_vya,
   input logic signed [19:0] rsp_vxb,
   input logic signed [19:0] rsp_vyb
);

   `DCR_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `DCR_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_hit) && $stable(rsp_vxa) && $stable(rsp_vya) && $stable(rsp_vxb) && $stable(rsp_vyb))
   `DCR_ASSERT(a_rst_empty, clock, reset |=> !rsp_valid)
   `DCR_ASSERT(a_rst_ready, clock, reset |=> req_ready)

endmodule

bind disk_elastic_collision_response dcr_checker u_dcr_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_hit(rsp_chan.hit),
   .rsp_vxa(rsp_chan.new_vel_x_a),
   .rsp_vya(rsp_chan.new_vel_y_a),
   .rsp_vxb(rsp_chan.new_vel_x_b),
   .rsp_vyb(rsp_chan.new_vel_y_b)
);
